/* rtl/kmc_pkg.sv */
package kmc_pkg;

    // Store geometry and counter width.
    localparam int MAX_KMER    = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int ADDR_W      = 2 * MAX_KMER;
    localparam int KLEN_W      = $clog2(MAX_KMER + 1);
    localparam int SHAMT_W     = KLEN_W + 1;

    // Fixed field widths of the ports.
    localparam int CMD_W   = 2;
    localparam int BASE_W  = 3;
    localparam int INDEX_W = 16;
    localparam int LEN_W   = 4;
    localparam int OUT_W   = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Highest base code that is a real nucleotide (A, G, C, T).
    localparam logic [BASE_W-1:0] BASE_LAST_VALID = 3'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic clear_step;
        logic inc_write;
        logic load_result;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic push_counts;
        logic clear_last;
    } dp_status_t;

endpackage

/* rtl/kmc_datapath.sv */
module kmc_datapath
    import kmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             ctrl,
    output dp_status_t            status,
    input  logic                  kmer_length_we,
    input  logic [LEN_W-1:0]      kmer_length,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [BASE_W-1:0]     base,
    input  logic [INDEX_W-1:0]    index,
    output logic [OUT_W-1:0]      count
);

    logic [COUNT_WIDTH-1:0] mem [2**ADDR_W];

    logic [LEN_W-1:0]       kmer_length_reg;
    logic [ADDR_W-1:0]      window_reg;
    logic [ADDR_W-1:0]      window_next;
    logic [KLEN_W-1:0]      valid_run_reg;
    logic [KLEN_W-1:0]      valid_run_next;
    logic [ADDR_W-1:0]      clear_ptr_reg;
    logic [ADDR_W-1:0]      inc_addr_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    logic [KLEN_W-1:0]      k_eff;
    logic [KLEN_W-1:0]      k_diff;
    logic [SHAMT_W-1:0]     shamt;
    logic [ADDR_W-1:0]      kmer_addr;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   base_ok;
    logic [COUNT_WIDTH-1:0] inc_value;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // Effective k-mer length: zero acts as one, too large acts as the maximum.
    always_comb
    begin
        if (kmer_length_reg == '0)
            k_eff = KLEN_W'(1);
        else if (kmer_length_reg > LEN_W'(MAX_KMER))
            k_eff = KLEN_W'(MAX_KMER);
        else
            k_eff = KLEN_W'(kmer_length_reg);
    end

    // Rolling window: the newest base enters the top digit.
    always_comb
    begin
        base_ok        = (base <= BASE_LAST_VALID);
        window_next    = {base[1:0], window_reg[ADDR_W-1:2]};
        valid_run_next = (valid_run_reg < KLEN_W'(MAX_KMER)) ?
                         valid_run_reg + KLEN_W'(1) : valid_run_reg;
        k_diff         = KLEN_W'(MAX_KMER) - k_eff;
        shamt          = {k_diff, 1'b0};
        kmer_addr      = window_next >> shamt;
    end

    assign status.push_counts = base_ok && (valid_run_next >= k_eff);
    assign status.clear_last  = (clear_ptr_reg == '1);

    // Read address: the requested index for a read, the new k-mer for a push.
    assign rd_addr = (cmd == CMD_READ) ? ADDR_W'(index) : kmer_addr;

    // Saturating increment of the fetched counter.
    assign inc_value = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);

    // One write port, shared by the clearing sweep and the counter update.
    always_comb
    begin
        wr_en   = ctrl.clear_step || ctrl.inc_write;
        wr_addr = ctrl.clear_step ? clear_ptr_reg : inc_addr_reg;
        wr_data = ctrl.clear_step ? '0 : inc_value;
    end

    // Counter store with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctrl.take_item)
            rd_data_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.take_item)
            inc_addr_reg <= kmer_addr;
        if (ctrl.load_result)
            count_reg <= rd_data_reg;
    end

    // Configuration, window, run length and clearing pointer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= LEN_W'(1);
            window_reg      <= '0;
            valid_run_reg   <= '0;
            clear_ptr_reg   <= '0;
        end
        else
        begin
            if (kmer_length_we)
                kmer_length_reg <= kmer_length;
            if (ctrl.take_item && cmd == CMD_PUSH)
            begin
                if (base_ok)
                begin
                    window_reg    <= window_next;
                    valid_run_reg <= valid_run_next;
                end
                else
                begin
                    valid_run_reg <= '0;
                end
            end
            else if (ctrl.take_item && cmd == CMD_CLEAR)
            begin
                window_reg    <= '0;
                valid_run_reg <= '0;
                clear_ptr_reg <= '0;
            end
            else if (ctrl.clear_step)
            begin
                clear_ptr_reg <= clear_ptr_reg + ADDR_W'(1);
            end
        end
    end

    assign count = OUT_W'(count_reg);

endmodule

/* rtl/kmc_ctrl.sv */
module kmc_ctrl
    import kmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CMD_W-1:0] cmd,
    output logic             out_valid,
    input  logic             out_stall,
    output ctrl_cmd_t        ctrl,
    input  dp_status_t       status
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   take;

    assign take = (state_reg == ST_IDLE) && in_valid;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd == CMD_PUSH && status.push_counts)
                        state_next = ST_INC;
                    else if (cmd == CMD_READ)
                        state_next = ST_LOAD;
                    else if (cmd == CMD_CLEAR)
                        state_next = ST_CLEAR;
                end
            end
            ST_INC:
            begin
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs to the datapath and the input handshake.
    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        ctrl.take_item   = take;
        ctrl.clear_step  = (state_reg == ST_CLEAR);
        ctrl.inc_write   = (state_reg == ST_INC);
        ctrl.load_result = (state_reg == ST_LOAD) && (!out_valid_reg || !out_stall);
    end

    // Output word flag: set on load, dropped once the word is taken.
    always_comb
    begin
        if (ctrl.load_result)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/kmer_occurrence_counter_core.sv */
// k-mer occurrence counter.
// The input channel (in_valid, in_stall) carries one word per item: cmd, base
// and index. A push shifts a base into the rolling window and, once enough
// valid bases have arrived, increments the counter of the current k-mer.
// A read returns one counter on the output channel (out_valid, out_stall).
// A clear empties the counter store and the window.
// The k-mer length is written through kmer_length_we and kmer_length; the user
// must write it only while the block is idle, as the block does not enforce it.
// A push that counts fetches its counter, then writes it back through the
// single write port in ST_INC; a push that does not count, or an unknown
// command, goes straight back to idle. A read fetches into the read data
// register, then ST_LOAD copies it to the output register and sets out_valid.
// After reset, and after a clear command, a clearing sweep writes zero to
// every counter, one per cycle, while in_stall is high.
// A finished word waits in the output register while the receiver stalls;
// pushes are still accepted meanwhile, and a following read holds in its
// load cycle until the output register is free.
module kmer_occurrence_counter_core
    import kmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               kmer_length_we,
    input  logic [LEN_W-1:0]   kmer_length,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [BASE_W-1:0]  base,
    input  logic [INDEX_W-1:0] index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [OUT_W-1:0]   count
);

    ctrl_cmd_t  ctrl;
    dp_status_t status;

    // Sequencer.
    kmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl),
        .status    (status)
    );

    // Window, counter store and output register.
    kmc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .status         (status),
        .kmer_length_we (kmer_length_we),
        .kmer_length    (kmer_length),
        .cmd            (cmd),
        .base           (base),
        .index          (index),
        .count          (count)
    );

endmodule

/* dv/kmer_occurrence_counter_core_tb.sv */
`timescale 1ns / 1ps

import kmc_pkg::*;

// Histogram predictor: a rolling window of bases, a run length of valid bases,
// the counter store and a queue of counts that reads are still owed.
class kmer_histogram_model;
    bit [COUNT_WIDTH-1:0] counters [0:(1 << ADDR_W) - 1];
    bit [ADDR_W-1:0]      window;
    int unsigned          run_len;
    bit [LEN_W-1:0]       length_reg;
    bit [ADDR_W-1:0]      last_counted;
    bit [OUT_W-1:0]       owed_counts [$];
    int unsigned          faults;

    function new();
        clear_store();
        length_reg   = 1;
        last_counted = '0;
        faults       = 0;
    endfunction

    function void clear_store();
        foreach (counters[i])
        begin
            counters[i] = '0;
        end
        window  = '0;
        run_len = 0;
    endfunction

    // Lengths of zero act as one, and lengths past the store act as the maximum.
    function int unsigned eff_len();
        if (length_reg == 0)
            return 1;
        if (length_reg > MAX_KMER)
            return MAX_KMER;
        return length_reg;
    endfunction

    function void push_base(logic [BASE_W-1:0] b);
        int unsigned         k;
        logic [ADDR_W-1:0]   kidx;
        // Any code above T breaks the run but leaves the window digits alone.
        if (b > BASE_LAST_VALID)
        begin
            run_len = 0;
            return;
        end
        window = {b[1:0], window[ADDR_W-1:2]};
        if (run_len < MAX_KMER)
            run_len++;
        k = eff_len();
        if (run_len < k)
            return;
        kidx         = window >> (2 * (MAX_KMER - k));
        last_counted = kidx;
        if (counters[kidx] != {COUNT_WIDTH{1'b1}})
            counters[kidx] = counters[kidx] + 1'b1;
    endfunction

    function void note_word(logic [CMD_W-1:0] c, logic [BASE_W-1:0] b,
                            logic [INDEX_W-1:0] idx);
        case (c)
            CMD_PUSH:  push_base(b);
            CMD_READ:  owed_counts.push_back(counters[idx[ADDR_W-1:0]][OUT_W-1:0]);
            CMD_CLEAR: clear_store();
            default:   ;
        endcase
    endfunction

    function void report(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        faults++;
        if (faults <= 10)
            $display("%0t: %s: expected count %0d, got %0d", $realtime, what, want, got);
    endfunction

    function void check_count(logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        if (owed_counts.size() == 0)
        begin
            report("count word with no read outstanding", '0, got);
            return;
        end
        want = owed_counts.pop_front();
        if (got !== want)
            report("count mismatch", want, got);
    endfunction
endclass

module kmer_occurrence_counter_core_tb;

    localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
    localparam logic [BASE_W-1:0] BASE_A    = 3'd0;
    localparam logic [BASE_W-1:0] BASE_G    = 3'd1;
    localparam logic [BASE_W-1:0] BASE_C    = 3'd2;
    localparam logic [BASE_W-1:0] BASE_T    = 3'd3;
    localparam logic [BASE_W-1:0] BASE_N    = 3'd4;

    // A clearing sweep leaves the input stalled while it runs, so the quiet
    // limit is longer than one sweep.
    localparam int unsigned QUIET_LIMIT    = 4 * (1 << ADDR_W);
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned ITEMS_PER_SET  = 150;

    logic               clk;
    logic               rst_n;
    logic               kmer_length_we;
    logic [LEN_W-1:0]   kmer_length;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd;
    logic [BASE_W-1:0]  base;
    logic [INDEX_W-1:0] index;
    logic               out_valid;
    logic               out_stall;
    logic [OUT_W-1:0]   count;

    kmer_histogram_model model;

    int unsigned burst_left;
    bit          gaps_on;
    int unsigned clears_left;
    int unsigned quiet_cycles;
    int unsigned stall_tick;
    int unsigned stall_style;
    logic [BASE_W-1:0] motif [0:3];
    int unsigned motif_pos;

    kmer_occurrence_counter_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .kmer_length_we (kmer_length_we),
        .kmer_length    (kmer_length),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .base           (base),
        .index          (index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .count          (count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver switches between stall styles every so often, including none.
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_style <= $urandom_range(0, 3);
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((stall_tick % 6) < 3);
        endcase
    end

    // Every count word taken is compared with the oldest outstanding read.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            model.check_count(count);
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one word, with a random gap when a burst runs out, and hold it
    // until it is taken. Called and left at a falling edge.
    task automatic send_word(input logic [CMD_W-1:0] c, input logic [BASE_W-1:0] b,
                             input logic [INDEX_W-1:0] idx);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd      <= c;
        base     <= b;
        index    <= idx;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        model.note_word(c, b, idx);
        @(negedge clk);
    endtask

    // Stop sending until every outstanding read has been answered.
    task automatic drain_counts();
        in_valid <= 1'b0;
        while (model.owed_counts.size() != 0)
            @(negedge clk);
    endtask

    // The length register is only written once the block has gone quiet and
    // any clearing sweep has finished.
    task automatic write_kmer_length(input logic [LEN_W-1:0] v);
        drain_counts();
        repeat (SETTLE_CYCLES) @(negedge clk);
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        kmer_length_we <= 1'b1;
        kmer_length    <= v;
        @(negedge clk);
        kmer_length_we   <= 1'b0;
        model.length_reg = v;
    endtask

    task automatic push(input logic [BASE_W-1:0] b);
        send_word(CMD_PUSH, b, INDEX_W'($urandom_range(0, 65535)));
    endtask

    task automatic read_last();
        send_word(CMD_READ, BASE_W'($urandom_range(0, 7)), model.last_counted);
    endtask

    // Mostly pushes of real bases, some following a repeating motif so that
    // counters build up; half of the reads target the k-mer that was just counted.
    task automatic send_random_word();
        int unsigned        roll;
        int unsigned        sel;
        int unsigned        klen;
        logic [INDEX_W-1:0] span;
        logic [BASE_W-1:0]  b;
        roll = $urandom_range(0, 999);
        klen = model.eff_len();
        span = INDEX_W'((32'd1 << (2 * klen)) - 1);
        if (roll < 20)
            send_word(CMD_SPARE, BASE_W'($urandom_range(0, 7)),
                      INDEX_W'($urandom_range(0, 65535)));
        else if (roll < 24 && clears_left != 0)
        begin
            clears_left--;
            send_word(CMD_CLEAR, BASE_W'($urandom_range(0, 7)),
                      INDEX_W'($urandom_range(0, 65535)));
        end
        else if (roll < 260)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
                read_last();
            else if (sel < 8)
                send_word(CMD_READ, BASE_W'($urandom_range(0, 7)),
                          INDEX_W'($urandom_range(0, 65535)) & span);
            else
                send_word(CMD_READ, BASE_W'($urandom_range(0, 7)),
                          INDEX_W'($urandom_range(0, 65535)));
        end
        else
        begin
            if ($urandom_range(0, 99) < 6)
                b = BASE_W'($urandom_range(4, 7));
            else if ($urandom_range(0, 2) == 0)
            begin
                b = motif[motif_pos % 4];
                motif_pos++;
            end
            else
                b = BASE_W'($urandom_range(0, 3));
            push(b);
        end
    endtask

    initial
    begin
        int unsigned set_lengths [0:10];
        set_lengths = '{1, 3, 2, 8, 0, 15, 4, 5, 6, 7, 9};

        model          = new();
        rst_n          = 1'b0;
        kmer_length_we = 1'b0;
        kmer_length    = LEN_W'(1);
        in_valid       = 1'b0;
        cmd            = CMD_PUSH;
        base           = BASE_A;
        index          = '0;
        out_stall      = 1'b0;
        burst_left     = 0;
        gaps_on        = 1'b1;
        clears_left    = 3;
        quiet_cycles   = 0;
        stall_tick     = 0;
        stall_style    = 0;
        motif_pos      = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Pairs of bases, with N and the other non-base codes breaking the run.
        write_kmer_length(LEN_W'(2));
        push(BASE_A);
        push(BASE_G);
        push(BASE_C);
        push(BASE_T);
        read_last();
        push(BASE_N);
        push(BASE_G);
        read_last();
        push(3'd7);
        push(BASE_T);
        push(BASE_T);
        push(3'd5);
        push(3'd6);
        read_last();
        send_word(CMD_READ, BASE_A, 16'hFFFF);
        send_word(CMD_READ, 3'd7, 16'h0000);
        send_word(CMD_SPARE, 3'd7, 16'hFFFF);

        // A zero length counts single bases; the window carries over.
        write_kmer_length(LEN_W'(0));
        push(BASE_C);
        read_last();

        // An oversized length counts whole windows once eight bases have run.
        write_kmer_length(LEN_W'(15));
        push(BASE_A);
        push(BASE_G);
        push(BASE_C);
        push(BASE_T);
        push(BASE_G);
        push(BASE_G);
        push(BASE_C);
        read_last();
        send_word(CMD_CLEAR, BASE_A, '0);
        read_last();

        // Random sets, one per length setting.
        foreach (set_lengths[s])
        begin
            write_kmer_length(LEN_W'(set_lengths[s]));
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int m = 0; m < 4; m++)
                motif[m] = BASE_W'($urandom_range(0, 3));
            for (int i = 0; i < ITEMS_PER_SET; i++)
            begin
                if (s == 2 && i == ITEMS_PER_SET / 2)
                    drain_counts();
                send_random_word();
            end
        end

        drain_counts();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (model.faults == 0 && model.owed_counts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
